// File: src/lsbl_pkg.sv
package lsbl_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    localparam int PIX_W     = 8;
    localparam int LABEL_W   = 3;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;
    localparam int THR_W     = 8;

    // Column index, row index of the labeled pixel, and input row that runs to height + 1.
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int OROW_W = $clog2(MAX_HEIGHT);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_INSIDE_THRESHOLD = CFG_IDX_W'(2);

    localparam logic [CFG_W-1:0] WIDTH_RESET     = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RESET    = CFG_W'(480);
    localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(100);

    localparam logic signed [LABEL_W-1:0] LABEL_OUT_FAR  = 3'sd3;
    localparam logic signed [LABEL_W-1:0] LABEL_OUT_EDGE = 3'sd1;
    localparam logic signed [LABEL_W-1:0] LABEL_IN_EDGE  = -3'sd1;
    localparam logic signed [LABEL_W-1:0] LABEL_IN_FAR   = -3'sd3;

    typedef struct packed {
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
        logic [THR_W-1:0] threshold;
    } lsbl_cfg_t;

    typedef struct packed {
        logic [COL_W-1:0] addr;
        logic             store;
        logic             sign;
        logic             due;
        logic             has_up;
        logic             has_down;
        logic             has_left;
        logic             has_right;
        logic             last;
    } lsbl_tag_t;

endpackage

// File: src/lsbl_if.sv
interface lsbl_pix_if;
    import lsbl_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] mask_pixel;
    logic             flush;

    modport source (output valid, output mask_pixel, output flush, input ready);
    modport sink (input valid, input mask_pixel, input flush, output ready);
endinterface

interface lsbl_label_if;
    import lsbl_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [LABEL_W-1:0] label;
    logic                      frame_last;

    modport source (output valid, output label, output frame_last, input ready);
    modport sink (input valid, input label, input frame_last, output ready);
endinterface

// File: src/lsbl_front.sv
module lsbl_front (
    input  logic                clk,
    input  logic                rst_n,
    input  lsbl_pkg::lsbl_cfg_t cfg,
    input  logic                restart,
    lsbl_pix_if.sink            pixels,
    input  logic                q_full,
    output logic                q_push,
    output lsbl_pkg::lsbl_tag_t q_tag
);
    import lsbl_pkg::*;

    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [ROW_W-1:0]  in_row_reg, in_row_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [OROW_W-1:0] out_row_reg, out_row_next;

    logic [CFG_W-1:0] in_col_inc;
    logic [CFG_W-1:0] out_col_inc;
    logic [CFG_W-1:0] out_row_inc;
    logic             drained;
    logic             skip;
    logic             due;
    logic             last;

    assign pixels.ready = !q_full;

    always_comb
    begin
        in_col_inc  = CFG_W'(in_col_reg) + CFG_W'(1);
        out_col_inc = CFG_W'(out_col_reg) + CFG_W'(1);
        out_row_inc = CFG_W'(out_row_reg) + CFG_W'(1);
        drained     = CFG_W'(in_row_reg) >= cfg.height;
        skip        = pixels.flush && !drained;
        q_push      = pixels.valid && pixels.ready && !skip;
        due         = (in_row_reg >= ROW_W'(2))
                      || (in_row_reg == ROW_W'(1) && in_col_reg != '0);
        last        = due && out_row_inc >= cfg.height && out_col_inc >= cfg.width;

        q_tag.addr      = in_col_reg;
        q_tag.store     = !drained;
        q_tag.sign      = !drained && (pixels.mask_pixel > cfg.threshold);
        q_tag.due       = due;
        q_tag.has_up    = out_row_reg != '0;
        q_tag.has_down  = out_row_inc < cfg.height;
        q_tag.has_left  = out_col_reg != '0;
        q_tag.has_right = out_col_inc < cfg.width;
        q_tag.last      = last;
    end

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (restart || (q_push && last))
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (q_push)
        begin
            if (due)
            begin
                if (out_col_inc >= cfg.width)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + OROW_W'(1);
                end
                else
                begin
                    out_col_next = COL_W'(out_col_inc);
                end
            end
            if (in_col_inc >= cfg.width)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + ROW_W'(1);
            end
            else
            begin
                in_col_next = COL_W'(in_col_inc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (CFG_W'(in_row_reg) <= cfg.height) || (CFG_W'(in_row_reg) == cfg.height + CFG_W'(1)))
        else $error("Input row ran past the drain row of the frame.");

endmodule

// File: src/lsbl_queue.sv
module lsbl_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  lsbl_pkg::lsbl_tag_t push_tag,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output lsbl_pkg::lsbl_tag_t head_tag
);
    import lsbl_pkg::*;

    lsbl_tag_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full     = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign head_tag = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_tag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push |-> !full) and (pop |-> !empty))
        else $error("Queue written while full or read while empty.");

endmodule

// File: src/lsbl_back.sv
module lsbl_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                restart,
    input  logic                empty,
    input  lsbl_pkg::lsbl_tag_t head_tag,
    output logic                pop,
    lsbl_label_if.source        labels
);
    import lsbl_pkg::*;

    // Each entry holds the sign two rows back in bit 0 and one row back in bit 1.
    logic [1:0] line_mem [MAX_WIDTH];
    logic [1:0] rd_data_reg;

    logic      s1_valid_reg, s1_valid_next;
    lsbl_tag_t s1_tag_reg;
    logic [2:0] win0_reg, win0_next;
    logic [2:0] win1_reg, win1_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [LABEL_W-1:0] label_reg;
    logic                      last_reg;

    logic [2:0]                col;
    logic                      s1_fire;
    logic                      wr_en;
    logic                      centre;
    logic                      other;
    logic                      touches;
    logic signed [LABEL_W-1:0] label_new;

    assign labels.valid      = out_valid_reg;
    assign labels.label      = label_reg;
    assign labels.frame_last = last_reg;

    always_comb
    begin
        col     = {s1_tag_reg.sign, rd_data_reg[1], rd_data_reg[0]};
        s1_fire = s1_valid_reg && (!s1_tag_reg.due || !out_valid_reg || labels.ready);
        pop     = !empty && (!s1_valid_reg || s1_fire);
        wr_en   = s1_fire && s1_tag_reg.store;
        centre  = win0_reg[1];
        other   = !centre;
        touches = (s1_tag_reg.has_up && win0_reg[0] == other)
                  || (s1_tag_reg.has_left && win1_reg[1] == other)
                  || (s1_tag_reg.has_right && col[1] == other)
                  || (s1_tag_reg.has_down && win0_reg[2] == other);
        if (centre)
        begin
            label_new = touches ? LABEL_IN_EDGE : LABEL_IN_FAR;
        end
        else
        begin
            label_new = touches ? LABEL_OUT_EDGE : LABEL_OUT_FAR;
        end

        s1_valid_next = pop || (s1_valid_reg && !s1_fire);

        win0_next = win0_reg;
        win1_next = win1_reg;
        if (restart || (s1_fire && s1_tag_reg.last))
        begin
            win0_next = '0;
            win1_next = '0;
        end
        else if (s1_fire)
        begin
            win1_next = win0_reg;
            win0_next = col;
        end

        out_valid_next = out_valid_reg && !labels.ready;
        if (s1_fire && s1_tag_reg.due)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rd_data_reg <= line_mem[head_tag.addr];
            s1_tag_reg  <= head_tag;
        end
        if (wr_en)
        begin
            line_mem[s1_tag_reg.addr] <= {col[2], col[1]};
        end
        if (s1_fire && s1_tag_reg.due)
        begin
            label_reg <= label_new;
            last_reg  <= s1_tag_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            win0_reg      <= '0;
            win1_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            win0_reg      <= win0_next;
            win1_reg      <= win1_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_last_is_due: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_tag_reg.last) |-> s1_tag_reg.due)
        else $error("Frame end marked on a beat that carries no label.");

    a_window_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_tag_reg.last) |=> (win0_reg == '0 && win1_reg == '0))
        else $error("Neighbor window not cleared after the last label of a frame.");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_fire) |=> (s1_valid_reg && $stable(s1_tag_reg)
        && ($past(rd_data_reg) === rd_data_reg)))
        else $error("Stalled line store stage lost its beat.");

endmodule

// File: src/level_set_boundary_labeler.sv
// Labels a raster stream of mask pixels by their 4-neighbors: a pixel above the threshold is
// inside, and each pixel gets 3 or 1 (outside) or -1 or -3 (inside), where 1 and -1 mark pixels
// that touch the other side within the image. It takes one beat per clock while labels are
// accepted; a label comes out image_width + 1 accepted beats after its pixel, so the last row is
// drained with flush or surplus pixel beats, and a flush before the frame's pixels are complete
// is dropped. Inside the block a beat passes the classifier, a two-entry queue, and a line store
// stage with a registered read, and the label is registered before it leaves. The line store
// needs no clearing after reset. Configuration writes restart the frame and must be made only
// while the block is idle.
module level_set_boundary_labeler (
    input  logic                              clk,
    input  logic                              rst_n,
    lsbl_pix_if.sink                          pixels,
    lsbl_label_if.source                      labels,
    input  logic                              cfg_we,
    input  logic [lsbl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lsbl_pkg::CFG_W-1:0]        cfg_data
);
    import lsbl_pkg::*;

    logic [CFG_W-1:0] width_reg, width_next;
    logic [CFG_W-1:0] height_reg, height_next;
    logic [THR_W-1:0] threshold_reg, threshold_next;
    logic             restart;
    lsbl_cfg_t        cfg;

    logic      q_push;
    logic      q_full;
    logic      q_pop;
    logic      q_empty;
    lsbl_tag_t q_tag;
    lsbl_tag_t head_tag;

    always_comb
    begin
        width_next     = width_reg;
        height_next    = height_reg;
        threshold_next = threshold_reg;
        restart        = 1'b0;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:
                begin
                    width_next = cfg_data;
                    restart    = 1'b1;
                end
                REG_IMAGE_HEIGHT:
                begin
                    height_next = cfg_data;
                    restart     = 1'b1;
                end
                REG_INSIDE_THRESHOLD:
                begin
                    threshold_next = cfg_data[THR_W-1:0];
                    restart        = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end

        if (width_reg < CFG_W'(2))
        begin
            cfg.width = CFG_W'(2);
        end
        else if (width_reg > CFG_W'(MAX_WIDTH))
        begin
            cfg.width = CFG_W'(MAX_WIDTH);
        end
        else
        begin
            cfg.width = width_reg;
        end

        if (height_reg < CFG_W'(1))
        begin
            cfg.height = CFG_W'(1);
        end
        else if (height_reg > CFG_W'(MAX_HEIGHT))
        begin
            cfg.height = CFG_W'(MAX_HEIGHT);
        end
        else
        begin
            cfg.height = height_reg;
        end

        cfg.threshold = threshold_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
            threshold_reg <= THRESHOLD_RESET;
        end
        else
        begin
            width_reg     <= width_next;
            height_reg    <= height_next;
            threshold_reg <= threshold_next;
        end
    end

    lsbl_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .restart (restart),
        .pixels  (pixels),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_tag   (q_tag)
    );

    lsbl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_tag (q_tag),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head_tag (head_tag)
    );

    lsbl_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .restart  (restart),
        .empty    (q_empty),
        .head_tag (head_tag),
        .pop      (q_pop),
        .labels   (labels)
    );

endmodule

// File: tb/lsbl_label_check.sv
module lsbl_label_check (
    input  logic                           clk,
    input  logic                           rst_n,
    lsbl_pix_if                            pixels,
    lsbl_label_if                          labels,
    input  logic                           cfg_we,
    input  logic [lsbl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lsbl_pkg::CFG_W-1:0]     cfg_data,
    output int                             errors,
    output int                             pending
);
    import lsbl_pkg::*;

    typedef struct packed {
        logic signed [LABEL_W-1:0] label;
        logic                      frame_last;
    } label_beat_t;

    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;
    logic [THR_W-1:0]  thr_reg;

    bit                two_rows_back [MAX_WIDTH];
    bit                one_row_back [MAX_WIDTH];
    logic [COL_W-1:0]  in_col;
    logic [ROW_W-1:0]  in_row;
    logic [COL_W-1:0]  out_col;
    logic [OROW_W-1:0] out_row;
    logic [2:0]        win_cur;
    logic [2:0]        win_prev;

    label_beat_t       label_queue [$];
    int                fail_count;

    function automatic void restart_frame();
        in_col   = '0;
        in_row   = '0;
        out_col  = '0;
        out_row  = '0;
        win_cur  = '0;
        win_prev = '0;
    endfunction

    task automatic predict_label(input logic [PIX_W-1:0] pix, input logic fl);
        int          w;
        int          h;
        bit          drained;
        bit          due;
        bit          touches;
        bit          last;
        bit          cur_sign;
        bit          centre;
        bit          other;
        logic [2:0]  col;
        label_beat_t exp_beat;

        w = (width_reg < 2) ? 2 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
        h = (height_reg < 1) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
        drained = int'(in_row) >= h;

        // A flush is only meaningful once every pixel of the frame is in.
        if (fl && !drained)
            return;

        cur_sign = 1'b0;
        col = {1'b0, one_row_back[in_col], two_rows_back[in_col]};
        if (!drained)
        begin
            cur_sign = pix > thr_reg;
            two_rows_back[in_col] = col[1];
            one_row_back[in_col] = cur_sign;
        end
        col[2] = cur_sign;

        due = (in_row >= 2) || (in_row == 1 && in_col >= 1);
        if (due)
        begin
            centre  = win_cur[1];
            other   = !centre;
            touches = 1'b0;
            if (out_row > 0 && win_cur[0] == other)
                touches = 1'b1;
            if (out_col > 0 && win_prev[1] == other)
                touches = 1'b1;
            if (int'(out_col) + 1 < w && col[1] == other)
                touches = 1'b1;
            if (int'(out_row) + 1 < h && win_cur[2] == other)
                touches = 1'b1;

            if (centre)
                exp_beat.label = touches ? LABEL_IN_EDGE : LABEL_IN_FAR;
            else
                exp_beat.label = touches ? LABEL_OUT_EDGE : LABEL_OUT_FAR;
            last = (int'(out_row) + 1 >= h) && (int'(out_col) + 1 >= w);
            exp_beat.frame_last = last;
            label_queue.push_back(exp_beat);

            if (last)
            begin
                restart_frame();
                return;
            end
            if (int'(out_col) + 1 >= w)
            begin
                out_col = '0;
                out_row = out_row + 1'b1;
            end
            else
            begin
                out_col = out_col + 1'b1;
            end
        end

        win_prev = win_cur;
        win_cur  = col;
        if (int'(in_col) + 1 >= w)
        begin
            in_col = '0;
            in_row = in_row + 1'b1;
        end
        else
        begin
            in_col = in_col + 1'b1;
        end
    endtask

    task automatic compare_label();
        label_beat_t exp_beat;

        if (label_queue.size() == 0)
        begin
            $error("label beat %0d with frame_last %0b arrived with nothing expected",
                   labels.label, labels.frame_last);
            fail_count++;
            return;
        end
        exp_beat = label_queue.pop_front();
        if (labels.label !== exp_beat.label)
        begin
            $error("label: expected %0d, actual %0d", exp_beat.label, labels.label);
            fail_count++;
        end
        if (labels.frame_last !== exp_beat.frame_last)
        begin
            $error("frame_last: expected %0b, actual %0b", exp_beat.frame_last,
                   labels.frame_last);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            thr_reg    = THRESHOLD_RESET;
            restart_frame();
            label_queue.delete();
            fail_count = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:
                    begin
                        width_reg = cfg_data;
                        restart_frame();
                    end
                    REG_IMAGE_HEIGHT:
                    begin
                        height_reg = cfg_data;
                        restart_frame();
                    end
                    REG_INSIDE_THRESHOLD:
                    begin
                        thr_reg = cfg_data[THR_W-1:0];
                        restart_frame();
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (pixels.valid && pixels.ready)
                predict_label(pixels.mask_pixel, pixels.flush);
            if (labels.valid && labels.ready)
                compare_label();
            errors  <= fail_count;
            pending <= label_queue.size();
        end
    end

endmodule

// File: tb/level_set_boundary_labeler_test.sv
module level_set_boundary_labeler_test;
    import lsbl_pkg::*;

    localparam int IDLE_LIMIT   = 5000;
    localparam int HOLD_CYCLES  = 300;
    localparam int ITEM_TARGET  = 1300;
    localparam int DRAIN_CYCLES = 10;
    localparam int CUT_PIXELS   = 200;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
    typedef enum int {STYLE_NOISE, STYLE_RECT, STYLE_DISC} frame_style_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int fault_count;
    int expected_left;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_requests;
    int cur_width;
    int cur_height;
    int cur_thr;
    int items_sent;

    lsbl_pix_if   pix_ch ();
    lsbl_label_if lab_ch ();

    level_set_boundary_labeler i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixels    (pix_ch),
        .labels    (lab_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lsbl_label_check i_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixels    (pix_ch),
        .labels    (lab_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (fault_count),
        .pending   (expected_left)
    );

    always #5 clk = ~clk;

    initial
    begin
        int hold_served;

        hold_served = 0;
        lab_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_served != hold_requests)
            begin
                hold_served++;
                lab_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            lab_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        int quiet_cycles;

        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((pix_ch.valid && pix_ch.ready) || (lab_ch.valid && lab_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic put_beat(input logic [PIX_W-1:0] pix, input logic fl);
        int gap;

        gap = 0;
        while (gap < 20 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_ch.valid      <= 1'b1;
        pix_ch.mask_pixel <= pix;
        pix_ch.flush      <= fl;
        do
            @(posedge clk);
        while (!pix_ch.ready);
    endtask

    task automatic settle();
        pix_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_left != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                                input logic [THR_W-1:0] t);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        cfg_index <= REG_INSIDE_THRESHOLD;
        cfg_data  <= CFG_W'(t);
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_width  = (w < 2) ? 2 : (w > MAX_WIDTH) ? MAX_WIDTH : int'(w);
        cur_height = (h < 1) ? 1 : (h > MAX_HEIGHT) ? MAX_HEIGHT : int'(h);
        cur_thr    = int'(t);
    endtask

    function automatic logic [PIX_W-1:0] shade_for(input bit inner);
        if (inner && cur_thr < 255)
            return PIX_W'($urandom_range(255, cur_thr + 1));
        if (inner)
            return '1;
        return PIX_W'($urandom_range(cur_thr, 0));
    endfunction

    task automatic send_frame(input frame_style_t style, input int pix_limit, output int sent);
        int r0;
        int r1;
        int c0;
        int c1;
        int cy;
        int cx;
        int rad;
        bit flip;
        bit inner;

        r0   = $urandom_range(cur_height - 1);
        r1   = $urandom_range(cur_height - 1, r0);
        c0   = $urandom_range(cur_width - 1);
        c1   = $urandom_range(cur_width - 1, c0);
        cy   = $urandom_range(cur_height - 1);
        cx   = $urandom_range(cur_width - 1);
        rad  = $urandom_range(1, (cur_width + cur_height) / 3 + 1);
        flip = 1'($urandom_range(1));
        sent = 0;
        for (int r = 0; r < cur_height; r++)
        begin
            for (int c = 0; c < cur_width; c++)
            begin
                if (sent >= pix_limit)
                    return;
                if ($urandom_range(99) < 4)
                    put_beat(PIX_W'($urandom_range(255)), 1'b1);
                if (style == STYLE_NOISE)
                begin
                    put_beat(PIX_W'($urandom_range(255)), 1'b0);
                end
                else
                begin
                    if (style == STYLE_RECT)
                        inner = r >= r0 && r <= r1 && c >= c0 && c <= c1;
                    else
                        inner = (r - cy) * (r - cy) + (c - cx) * (c - cx) <= rad * rad;
                    inner = inner ^ flip ^ ($urandom_range(99) < 3);
                    put_beat(shade_for(inner), 1'b0);
                end
                sent++;
            end
        end
        // The last row and one more pixel drain through flush or surplus pixel beats.
        repeat (cur_width + 1)
        begin
            put_beat(PIX_W'($urandom_range(255)), $urandom_range(99) < 70);
            sent++;
        end
    endtask

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_SEND:
            begin
                send_idle_pct  = 53;
                recv_stall_pct = 0;
            end
            IDLE_RECV:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 53;
            end
            IDLE_BOTH:
            begin
                send_idle_pct  = 9;
                recv_stall_pct = 9;
            end
            default:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    initial
    begin
        int               frame_no;
        int               n;
        int               pick;
        int               limit;
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        logic [THR_W-1:0] t;

        pix_ch.valid      <= 1'b0;
        pix_ch.mask_pixel <= '0;
        pix_ch.flush      <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= REG_IMAGE_WIDTH;
        cfg_data          <= '0;
        set_idle(IDLE_NONE);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Smallest frame: an early flush is dropped, a surplus pixel acts as a flush.
        write_config(CFG_W'(2), CFG_W'(1), THR_W'(0));
        put_beat(8'hFF, 1'b1);
        put_beat(8'h00, 1'b0);
        put_beat(8'hFF, 1'b0);
        put_beat(8'h5A, 1'b1);
        put_beat(8'hFF, 1'b0);
        put_beat(8'h00, 1'b1);

        // Sizes below the range saturate; the top threshold leaves nothing inside.
        write_config(CFG_W'(0), CFG_W'(0), THR_W'(255));
        put_beat(8'hFF, 1'b0);
        put_beat(8'hFF, 1'b0);
        repeat (3) put_beat(8'hA5, 1'b1);

        write_config(CFG_W'(3), CFG_W'(3), THR_W'(254));
        put_beat(8'hFF, 1'b0);
        put_beat(8'hFF, 1'b0);
        put_beat(8'hFF, 1'b0);
        put_beat(8'hFF, 1'b0);
        put_beat(8'hFF, 1'b0);
        put_beat(8'h00, 1'b0);
        put_beat(8'hFE, 1'b0);
        put_beat(8'h00, 1'b0);
        put_beat(8'h00, 1'b0);
        repeat (4) put_beat(8'h00, 1'b1);

        items_sent = 0;
        frame_no   = 0;
        while (items_sent < ITEM_TARGET)
        begin
            set_idle(idle_mode_t'((frame_no / 6) % 4));
            if (frame_no == 2)
            begin
                write_config(CFG_W'(16), CFG_W'(12), THR_W'($urandom_range(255)));
                hold_requests++;
                send_frame(STYLE_DISC, cur_width * cur_height, n);
                items_sent += n;
            end
            else if (frame_no == 7)
            begin
                write_config(CFG_W'(MAX_WIDTH), CFG_W'(1), THR_W'($urandom_range(255)));
                send_frame(STYLE_RECT, CUT_PIXELS, n);
                items_sent += n;
            end
            else if (frame_no == 13)
            begin
                write_config(CFG_W'(2), '1, THR_W'($urandom_range(255)));
                send_frame(STYLE_DISC, CUT_PIXELS, n);
                items_sent += n;
            end
            else if (frame_no == 19)
            begin
                write_config('1, CFG_W'(1), '1);
                send_frame(STYLE_NOISE, CUT_PIXELS, n);
                items_sent += n;
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 5)
                    w = CFG_W'($urandom_range(1));
                else if (pick < 15)
                    w = CFG_W'($urandom_range(70, 15));
                else
                    w = CFG_W'($urandom_range(12, 2));
                if (w > 14)
                    h = CFG_W'($urandom_range(3, 1));
                else if ($urandom_range(99) < 5)
                    h = '0;
                else
                    h = CFG_W'($urandom_range(10, 1));
                pick = $urandom_range(99);
                if (pick < 10)
                    t = '0;
                else if (pick < 20)
                    t = '1;
                else
                    t = THR_W'($urandom_range(255));
                write_config(w, h, t);
                limit = cur_width * cur_height;
                // Now and then a frame is cut short and restarted by the next write.
                if ($urandom_range(99) < 6)
                    limit = $urandom_range(limit - 1, 1);
                send_frame(frame_style_t'($urandom_range(2)), limit, n);
                items_sent += n;
            end
            frame_no++;
        end

        settle();
        if (fault_count == 0 && expected_left == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
